FILE: sv/pilot_pwm_measure_check_macros.svh
// Assertion macros for the pilot PWM measurement check.
// Used by the checker module; no other dependencies.
`ifndef PILOT_PWM_MEASURE_CHECK_MACROS_SVH
`define PILOT_PWM_MEASURE_CHECK_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PPMC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ppmc assertion failed");

// Next-cycle implication, disabled in reset.
`define PPMC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ppmc assertion failed");

`endif

FILE: sv/ppmc_pkg.sv
// Types and constants for the pilot PWM measurement check.
// No dependencies.
`default_nettype none
package ppmc_pkg;
    localparam int NUM_BITS = 57;   // widest dividend
    localparam int DIV_BITS = 32;   // divisor width
    localparam int LANES    = 4;    // period, high, freq, duty
    localparam int NUM_CFG  = 5;
    localparam int CFG_IDX_BITS = 3;

    localparam int LANE_PERIOD = 0;
    localparam int LANE_HIGH   = 1;
    localparam int LANE_FREQ   = 2;
    localparam int LANE_DUTY   = 3;

    localparam logic [2:0] CFG_RATE     = 3'd0;
    localparam logic [2:0] CFG_FREQ_MIN = 3'd1;
    localparam logic [2:0] CFG_FREQ_MAX = 3'd2;
    localparam logic [2:0] CFG_DUTY_MIN = 3'd3;
    localparam logic [2:0] CFG_DUTY_MAX = 3'd4;

    localparam logic [23:0] US_Q4_SCALE = 24'd16000000;
    localparam logic [16:0] DUTY_ONE    = 17'd65536;
    localparam logic [31:0] U32_MAX     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                                valid;
        logic                                good;
        logic                                cap_ok;
        logic signed [14:0]                  mv;
        logic [DIV_BITS-1:0]                 rate;
        logic [DIV_BITS-1:0]                 period;
        logic [LANES-1:0][NUM_BITS-1:0]      num;
        logic [LANES-1:0][DIV_BITS-1:0]      rem;
        logic [LANES-1:0][NUM_BITS-1:0]      quo;
    } t_item;
endpackage
`default_nettype wire

FILE: sv/ppmc_if.sv
// Request channels of the pilot PWM measurement check.
// No dependencies.
`default_nettype none
interface ppmc_in_if;
    logic               valid;
    logic               ready;
    logic               capture_ok;
    logic [31:0]        period_count;
    logic [31:0]        high_count;
    logic signed [14:0] pilot_mv;
    modport source (output valid, capture_ok, period_count, high_count, pilot_mv,
                    input ready);
    modport sink   (input valid, capture_ok, period_count, high_count, pilot_mv,
                    output ready);
endinterface

interface ppmc_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] pilot_mv_out;
    logic               capture_ok_out;
    logic [31:0]        period_us_q4;
    logic [31:0]        high_us_q4;
    logic [31:0]        freq_q4;
    logic [16:0]        duty_q16;
    logic               pwm_ok;
    modport source (output valid, pilot_mv_out, capture_ok_out, period_us_q4,
                    high_us_q4, freq_q4, duty_q16, pwm_ok, input ready);
    modport sink   (input valid, pilot_mv_out, capture_ok_out, period_us_q4,
                    high_us_q4, freq_q4, duty_q16, pwm_ok, output ready);
endinterface
`default_nettype wire

FILE: sv/ppmc_cell.sv
// One divider cell: retires one quotient bit of all four divisions.
// Depends on ppmc_pkg.
`default_nettype none
module ppmc_cell
    import ppmc_pkg::*;
#(
    parameter int BIT_POS = 0
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire t_item i_item,
    output t_item      o_item
);
    t_item r_item;
    t_item n_item;

    always_comb begin
        logic [DIV_BITS-1:0] d;
        logic [DIV_BITS:0]   r;
        logic                qb;
        n_item = i_item;
        for (int l = 0; l < LANES; l++) begin
            d  = (l < LANE_FREQ) ? i_item.rate : i_item.period;
            r  = {i_item.rem[l], i_item.num[l][BIT_POS]};
            qb = (r >= {1'b0, d});
            // subtract when the divisor fits
            if (qb) begin
                r = r - {1'b0, d};
            end
            n_item.rem[l] = r[DIV_BITS-1:0];
            n_item.quo[l] = {i_item.quo[l][NUM_BITS-2:0], qb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;
endmodule
`default_nettype wire

FILE: sv/pilot_pwm_measure_check.sv
// Pilot PWM measurement check, top level.
// Depends on ppmc_pkg, ppmc_if and ppmc_cell.
//
// Usage: one request on i_in carries a capture (flag, period and high
// time in timer ticks, pilot voltage). One result leaves on o_out per
// request, in order: period and high time in 1/16 us, frequency in
// 1/16 Hz, duty in 1/65536 and the window flag; invalid captures give
// zero results with voltage and flag copied.
// One product stage, a row of 57 divider cells each retiring one quotient
// bit for all four divisions, one output stage. Throughput is one request
// per cycle. Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data
// while idle; the user must ensure this, the block does not. Reset
// (synchronous, active low) empties the pipeline and loads the default
// rate and windows. When the receiver stalls with a result held, the
// whole pipeline holds and i_in.ready drops until the result is taken.
`default_nettype none
module pilot_pwm_measure_check
    import ppmc_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [31:0]             i_cfg_data,
    ppmc_in_if.sink                      i_in,
    ppmc_out_if.source                   o_out
);
    localparam logic [32:0] COUNT_MASK = (33'd1 << COUNT_BITS) - 33'd1;

    logic [31:0] r_rate, r_freq_min, r_freq_max;
    logic [16:0] r_duty_min, r_duty_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate     <= 32'd1000000;
            r_freq_min <= 32'd15680;
            r_freq_max <= 32'd16320;
            r_duty_min <= 17'd1966;
            r_duty_max <= 17'd63570;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RATE:     r_rate     <= i_cfg_data;
                CFG_FREQ_MIN: r_freq_min <= i_cfg_data;
                CFG_FREQ_MAX: r_freq_max <= i_cfg_data;
                CFG_DUTY_MIN: r_duty_min <= i_cfg_data[16:0];
                CFG_DUTY_MAX: r_duty_max <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    logic r_out_valid;
    logic w_en;
    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    // product stage
    t_item r_s0;
    t_item n_s0;
    always_comb begin
        logic [31:0] per, hi;
        per = i_in.period_count & COUNT_MASK[31:0];
        hi  = i_in.high_count & COUNT_MASK[31:0];
        n_s0        = '0;
        n_s0.valid  = i_in.valid;
        n_s0.good   = i_in.capture_ok && (per != 32'd0) && (r_rate != 32'd0);
        n_s0.cap_ok = i_in.capture_ok;
        n_s0.mv     = i_in.pilot_mv;
        n_s0.rate   = r_rate;
        n_s0.period = per;
        n_s0.num[LANE_PERIOD] = {1'b0, {24'd0, per} * {32'd0, US_Q4_SCALE}};
        n_s0.num[LANE_HIGH]   = {1'b0, {24'd0, hi} * {32'd0, US_Q4_SCALE}};
        n_s0.num[LANE_FREQ]   = {21'd0, r_rate, 4'd0};
        n_s0.num[LANE_DUTY]   = {9'd0, hi, 16'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (w_en) begin
            r_s0 <= n_s0;
        end
    end

    t_item w_stage [0:NUM_BITS];
    assign w_stage[0] = r_s0;

    for (genvar k = 0; k < NUM_BITS; k++) begin : g_cell
        ppmc_cell #(.BIT_POS(NUM_BITS - 1 - k)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_item (w_stage[k]),
            .o_item (w_stage[k+1])
        );
    end

    // saturate, window check
    t_item       w_last;
    logic [31:0] w_per, w_hi, w_freq;
    logic [16:0] w_duty;
    logic        w_ok;
    assign w_last = w_stage[NUM_BITS];

    function automatic logic [31:0] sat32(input logic [NUM_BITS-1:0] q);
        return (|q[NUM_BITS-1:32]) ? U32_MAX : q[31:0];
    endfunction

    always_comb begin
        w_per  = '0;
        w_hi   = '0;
        w_freq = '0;
        w_duty = '0;
        w_ok   = 1'b0;
        if (w_last.good) begin
            w_per  = sat32(w_last.quo[LANE_PERIOD]);
            w_hi   = sat32(w_last.quo[LANE_HIGH]);
            w_freq = sat32(w_last.quo[LANE_FREQ]);
            w_duty = (w_last.quo[LANE_DUTY] > {40'd0, DUTY_ONE}) ? DUTY_ONE
                   : w_last.quo[LANE_DUTY][16:0];
            w_ok   = (w_freq >= r_freq_min) && (w_freq <= r_freq_max) &&
                     (w_duty >= r_duty_min) && (w_duty <= r_duty_max);
        end
    end

    logic signed [14:0] r_mv;
    logic               r_cap_ok, r_pwm_ok;
    logic [31:0]        r_per, r_hi, r_freq;
    logic [16:0]        r_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_last.valid;
            r_mv        <= w_last.mv;
            r_cap_ok    <= w_last.cap_ok;
            r_per       <= w_per;
            r_hi        <= w_hi;
            r_freq      <= w_freq;
            r_duty      <= w_duty;
            r_pwm_ok    <= w_ok;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.pilot_mv_out   = r_mv;
    assign o_out.capture_ok_out = r_cap_ok;
    assign o_out.period_us_q4   = r_per;
    assign o_out.high_us_q4     = r_hi;
    assign o_out.freq_q4        = r_freq;
    assign o_out.duty_q16       = r_duty;
    assign o_out.pwm_ok         = r_pwm_ok;
endmodule
`default_nettype wire

FILE: sv/ppmc_checker.sv
// Port-level checks for the pilot PWM measurement check, with bind.
// Depends on pilot_pwm_measure_check_macros.svh and the top level.
`default_nettype none
`include "pilot_pwm_measure_check_macros.svh"
module ppmc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_cap_ok,
    input wire logic [31:0] i_period,
    input wire logic [16:0] i_duty,
    input wire logic        i_pwm_ok
);
    `PPMC_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_pwm_ok))
    `PPMC_ASSERT_IMP(a_stall_ready, i_clk, i_rst_n, i_out_valid && !i_out_ready, !i_in_ready)
    `PPMC_ASSERT_IMP(a_duty_cap, i_clk, i_rst_n, i_out_valid, i_duty <= 17'd65536)
    `PPMC_ASSERT_IMP(a_invalid_zero, i_clk, i_rst_n, i_out_valid && !i_cap_ok, (i_period == 32'd0) && !i_pwm_ok)
endmodule

bind pilot_pwm_measure_check ppmc_checker u_ppmc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_cap_ok   (o_out.capture_ok_out),
    .i_period   (o_out.period_us_q4),
    .i_duty     (o_out.duty_q16),
    .i_pwm_ok   (o_out.pwm_ok)
);
`default_nettype wire

FILE: bench/ppmc_bench_if.sv
// Bench package of measurement and window types; the RTL's own ppmc_if.sv
// is compiled alongside, so this file only holds bench-side helpers.
// Depends on ppmc_pkg.
`timescale 1ns / 100ps
`default_nettype none
package ppmc_bench_pkg;
    import ppmc_pkg::*;

    typedef struct packed {
        logic signed [14:0] mv;
        logic               cap_ok;
        logic [31:0]        period_q4;
        logic [31:0]        high_q4;
        logic [31:0]        freq;
        logic [16:0]        duty;
        logic               good;
    } t_meas;

    typedef struct {
        logic [31:0] rate;
        logic [31:0] fmin;
        logic [31:0] fmax;
        logic [16:0] dmin;
        logic [16:0] dmax;
    } t_windows;
endpackage
`default_nettype wire

FILE: bench/ppmc_checker.sv
// Checker for the pilot PWM measurement check: predicts each result from
// the accepted request and the register copy, compares in order.
// Depends on ppmc_pkg, ppmc_bench_pkg and ppmc_if.
`timescale 1ns / 100ps
`default_nettype none
module ppmc_scoreboard
    import ppmc_pkg::*;
    import ppmc_bench_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    ppmc_in_if               i_in,
    ppmc_out_if              i_out,
    output int               o_errors,
    output int               o_pending
);
    t_windows win;
    t_meas    meas_q[$];

    function automatic t_meas measure(logic ok, logic [31:0] per, logic [31:0] hi,
                                      logic signed [14:0] mv, t_windows w);
        t_meas      m;
        logic [63:0] q;
        m = '0;
        m.mv = mv;
        m.cap_ok = ok;
        if (ok && per != 0 && w.rate != 0) begin
            q = ({32'd0, per} * 64'd16000000) / {32'd0, w.rate};
            m.period_q4 = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            q = ({32'd0, hi} * 64'd16000000) / {32'd0, w.rate};
            m.high_q4 = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            q = ({32'd0, w.rate} * 64'd16) / {32'd0, per};
            m.freq = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            q = ({32'd0, hi} * 64'd65536) / {32'd0, per};
            m.duty = (q > 64'd65536) ? 17'd65536 : q[16:0];
            m.good = m.freq >= w.fmin && m.freq <= w.fmax &&
                     m.duty >= w.dmin && m.duty <= w.dmax;
        end
        return m;
    endfunction

    always @(posedge i_clk) begin
        t_meas e;
        int    errs;
        errs = 0;
        if (!i_rst_n) begin
            win.rate <= 32'd1000000;
            win.fmin <= 32'd15680;
            win.fmax <= 32'd16320;
            win.dmin <= 17'd1966;
            win.dmax <= 17'd63570;
            meas_q.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RATE:     win.rate <= i_cfg_data;
                    CFG_FREQ_MIN: win.fmin <= i_cfg_data;
                    CFG_FREQ_MAX: win.fmax <= i_cfg_data;
                    CFG_DUTY_MIN: win.dmin <= i_cfg_data[16:0];
                    CFG_DUTY_MAX: win.dmax <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                meas_q.push_back(measure(i_in.capture_ok, i_in.period_count,
                                         i_in.high_count, i_in.pilot_mv, win));
            if (i_out.valid && i_out.ready) begin
                if (meas_q.size() == 0) begin
                    $error("result with no request pending");
                    errs++;
                end else begin
                    e = meas_q.pop_front();
                    if (e.mv !== i_out.pilot_mv_out) begin
                        $error("pilot_mv_out exp %0d got %0d", e.mv, i_out.pilot_mv_out);
                        errs++;
                    end
                    if (e.cap_ok !== i_out.capture_ok_out) begin
                        $error("capture_ok_out exp %0d got %0d", e.cap_ok,
                               i_out.capture_ok_out);
                        errs++;
                    end
                    if (e.period_q4 !== i_out.period_us_q4) begin
                        $error("period_us_q4 exp %0d got %0d", e.period_q4,
                               i_out.period_us_q4);
                        errs++;
                    end
                    if (e.high_q4 !== i_out.high_us_q4) begin
                        $error("high_us_q4 exp %0d got %0d", e.high_q4, i_out.high_us_q4);
                        errs++;
                    end
                    if (e.freq !== i_out.freq_q4) begin
                        $error("freq_q4 exp %0d got %0d", e.freq, i_out.freq_q4);
                        errs++;
                    end
                    if (e.duty !== i_out.duty_q16) begin
                        $error("duty_q16 exp %0d got %0d", e.duty, i_out.duty_q16);
                        errs++;
                    end
                    if (e.good !== i_out.pwm_ok) begin
                        $error("pwm_ok exp %0d got %0d", e.good, i_out.pwm_ok);
                        errs++;
                    end
                end
            end
            o_errors <= o_errors + errs;
            o_pending <= meas_q.size();
        end
    end
endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Stimulus and verdict for the pilot PWM measurement check.
// Depends on ppmc_pkg, ppmc_if, ppmc_bench_pkg and ppmc_scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import ppmc_pkg::*;

    localparam int LATENCY = 59;
    localparam int WATCHDOG = 4000;
    localparam logic [2:0] CFG_NONE = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [31:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;

    ppmc_in_if  req_ch ();
    ppmc_out_if res_ch ();

    pilot_pwm_measure_check dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_in(req_ch), .o_out(res_ch)
    );

    ppmc_scoreboard u_scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_in(req_ch), .i_out(res_ch),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.capture_ok = 1'b0;
        req_ch.period_count = '0;
        req_ch.high_count = '0;
        req_ch.pilot_mv = '0;
        res_ch.ready = 1'b0;
    end

    // Watchdog: count cycles with nothing accepted.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int n;
        wait (i_rst_n);
        while (1) begin
            @(negedge i_clk);
            if (hold_off) begin
                res_ch.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (n > 0) begin
                res_ch.ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Issue one capture; gaps drawn per request. Leaves valid high on return.
    task automatic send_capture(input logic ok, input logic [31:0] per,
                                input logic [31:0] hi, input logic signed [14:0] mv,
                                input bit gaps);
        int n;
        n = gaps ? $urandom_range(0, 6) : 0;
        if (n > 0) begin
            req_ch.valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.capture_ok <= ok;
        req_ch.period_count <= per;
        req_ch.high_count <= hi;
        req_ch.pilot_mv <= mv;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid at once so the last request is not offered again.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    function automatic logic signed [14:0] rand_mv();
        return 15'($signed($urandom_range(0, 30000)) - 15000);
    endfunction

    // Mostly pilot-like captures near the current rate, rest wide noise or tiny counts.
    task automatic random_capture(input logic [31:0] rate, input bit gaps);
        logic [31:0] per, hi;
        int          kind;
        kind = $urandom_range(0, 9);
        if (kind < 6 && rate != 0) begin
            per = rate / 1000 + $urandom_range(0, 40) - 20;
            if (per == 0) per = 1;
            hi = (per * $urandom_range(0, 100)) / 100;
        end else if (kind < 8) begin
            per = $urandom;
            hi = $urandom;
        end else begin
            per = $urandom_range(0, 16);
            hi = $urandom_range(0, 40);
        end
        send_capture($urandom_range(0, 9) != 0, per, hi, rand_mv(), gaps);
    endtask

    initial begin
        logic [31:0] rates[6];
        logic [31:0] rate;
        rates = '{32'd1000000, 32'd1, 32'hFFFF_FFFF, 32'd48000000, 32'd0, 32'd32768};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes and special cases at reset settings.
        send_capture(1'b1, 32'd1000, 32'd500, 15'sd15000, 1'b1);
        send_capture(1'b1, 32'd1000, 32'd50, -15'sd15000, 1'b1);
        send_capture(1'b0, 32'd1000, 32'd500, 15'sd0, 1'b1);
        send_capture(1'b1, 32'd0, 32'd500, 15'sd1, 1'b1);
        send_capture(1'b1, 32'd1000, 32'd2000, -15'sd1, 1'b1);
        send_capture(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'sd16383, 1'b1);
        send_capture(1'b1, 32'd1, 32'hFFFF_FFFF, -15'sd16384, 1'b1);
        send_capture(1'b1, 32'd1, 32'd0, 15'sd0, 1'b1);
        send_capture(1'b1, 32'hFFFF_FFFF, 32'd0, 15'sd0, 1'b1);
        send_capture(1'b1, 32'd1020, 32'd30, 15'sd12000, 1'b1);
        send_capture(1'b1, 32'd980, 32'd970, 15'sd9000, 1'b1);
        drain();

        // Rate zero makes everything invalid; inverted and open windows.
        write_reg(CFG_RATE, 32'd0);
        send_capture(1'b1, 32'd1000, 32'd500, 15'sd6000, 1'b1);
        drain();
        write_reg(CFG_RATE, 32'hFFFF_FFFF);
        write_reg(CFG_FREQ_MIN, 32'hFFFF_FFFF);
        write_reg(CFG_FREQ_MAX, 32'd0);
        send_capture(1'b1, 32'd1, 32'd1, 15'sd0, 1'b1);
        drain();
        write_reg(CFG_FREQ_MIN, 32'd0);
        write_reg(CFG_FREQ_MAX, 32'hFFFF_FFFF);
        write_reg(CFG_DUTY_MIN, 32'd65536);
        write_reg(CFG_DUTY_MAX, 32'h1FFFF);
        // unknown index must leave every register alone
        write_reg(CFG_NONE, $urandom);
        send_capture(1'b1, 32'd10, 32'd40, 15'sd0, 1'b1);
        send_capture(1'b1, 32'd10, 32'd5, 15'sd0, 1'b1);
        drain();

        // Random phases over several register settings.
        for (int ph = 0; ph < 12; ph++) begin
            rate = rates[ph % 6];
            write_reg(CFG_RATE, rate);
            write_reg(CFG_FREQ_MIN, (ph % 4 == 0) ? 32'd0 : rate * 16 / 1030);
            write_reg(CFG_FREQ_MAX, (ph % 4 == 3) ? 32'hFFFF_FFFF : rate * 16 / 970);
            write_reg(CFG_DUTY_MIN, $urandom_range(0, 20000));
            write_reg(CFG_DUTY_MAX, (ph % 3 == 0) ? 32'h1FFFF : $urandom_range(40000, 65536));
            if (ph == 5) hold_off = 1'b1;
            for (int k = 0; k < 150; k++)
                random_capture(rate, (k % 50) < 35);
            drain();
        end

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+sv
sv/ppmc_pkg.sv
sv/ppmc_if.sv
sv/ppmc_cell.sv
sv/pilot_pwm_measure_check.sv
sv/ppmc_checker.sv
bench/ppmc_bench_if.sv
bench/ppmc_checker.sv
bench/testbench.sv
